// ===== sv/cuart_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Console UART package
// Shared types and constants for the console port: channel payloads, the
// command passed from the decoder to the execution side, register offsets.
// ---------------------------------------------------------------------------
package cuart_pkg;

   // Receive FIFO sizing
   localparam int FIFO_DEPTH = 16;
   localparam int RX_AW      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int RX_CNT_W   = $clog2(FIFO_DEPTH + 1);
   localparam int RX_FREE_W  = 5;

   // Command queue between decoder and execution side
   localparam int QUEUE_DEPTH = 2;

   // Item kinds on the request channel
   localparam logic [1:0] OP_RX_BYTE = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_WRITE   = 2'd2;

   // Register offsets
   localparam logic [3:0] OFF_DATA       = 4'd0;
   localparam logic [3:0] OFF_STATUS     = 4'd1;
   localparam logic [3:0] OFF_CONTROL    = 4'd2;
   localparam logic [3:0] OFF_IRQ_STATUS = 4'd3;

   // Only single-byte accesses take effect
   localparam logic [3:0] ACCESS_BYTE = 4'd1;

   // Characters
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // Decoded command
   typedef enum logic [3:0] {
      CMD_NOP,
      CMD_PUSH,
      CMD_POP,
      CMD_RD_STATUS,
      CMD_RD_CTRL,
      CMD_RD_IRQ,
      CMD_WR_CTRL,
      CMD_TX,
      CMD_TX_NL
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

   // Request payload
   typedef struct packed {
      logic [1:0] op;
      logic [3:0] reg_offset;
      logic [3:0] access_bytes;
      logic [7:0] write_data;
      logic [7:0] rx_byte;
   } req_type;

   // Result payload
   typedef struct packed {
      logic [7:0]           read_data;
      logic                 tx_valid;
      logic [7:0]           tx_char;
      logic                 irq_level;
      logic [RX_FREE_W-1:0] rx_free;
      logic                 last;
   } rsp_type;

endpackage
`default_nettype wire

// ===== sv/console_uart_with_rx_fifo.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Console UART with receive FIFO
// Byte-wide console port: host receive bytes, bus reads and bus writes.
// ---------------------------------------------------------------------------
// The port takes one item per clock while the command queue is not full: a
// host byte, a bus read or a bus write. Every item gives one result, except a
// write of a newline to the data register, which gives CR then LF. An item is
// decoded into a two-entry command queue when it is accepted, then executed
// into the output register, from which its result is presented; the queue
// lets requests keep flowing until it fills while a result waits in the
// output register. The receive FIFO holds FIFO_DEPTH bytes in flip-flops; a
// byte that arrives when it is full is dropped. irq_level and rx_free report
// the state after the item. Bit 0 of control is the receive interrupt
// enable; status bit 1 is transmit ready, bit 0 receive ready.
module console_uart_with_rx_fifo
   import cuart_pkg::*;
(
   input  var logic    clock,
   input  var logic    reset,
   input  var logic    req_valid,
   output var logic    req_stall,
   input  var req_type req_data,
   output var logic    rsp_valid,
   input  var logic    rsp_stall,
   output var rsp_type rsp_data
);

   cmd_type dec_cmd;
   cmd_type head_cmd;
   logic    q_full, q_head_valid, q_pop;

   cuart_front u_front (
      .req_data (req_data),
      .cmd      (dec_cmd)
   );

   cuart_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_cmd   (dec_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_cmd   (head_cmd)
   );

   cuart_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_head_valid),
      .cmd       (head_cmd),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign req_stall = q_full;

   // A CR that is not the final result is followed at once by its LF
   a_cr_then_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.tx_valid && !rsp_data.last
      |=> rsp_valid && rsp_data.tx_valid && rsp_data.last && (rsp_data.tx_char == CHAR_LF))
      else $error("newline transfer not followed by LF");

   // Transmit results never carry read data
   a_tx_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.tx_valid |-> rsp_data.read_data == 8'd0)
      else $error("transmit result carries read data");

   // Only a newline can leave a result without last set
   a_not_last_is_cr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.tx_valid && (rsp_data.tx_char == CHAR_CR))
      else $error("non-final result that is not CR");

endmodule
`default_nettype wire

// ===== sv/cuart_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Console UART request decoder
// Classifies each incoming item into a single command for the execution
// side: FIFO push or pop, register read, control write, transmit or no-op.
// ---------------------------------------------------------------------------
module cuart_front
   import cuart_pkg::*;
(
   input  var req_type req_data,
   output var cmd_type cmd
);

   logic byte_access;

   assign byte_access = (req_data.access_bytes == ACCESS_BYTE);

   // Decode op, offset and size into a command
   always_comb begin
      cmd.kind = CMD_NOP;
      cmd.data = req_data.write_data;
      unique case (req_data.op)
         OP_RX_BYTE: begin
            cmd.kind = CMD_PUSH;
            cmd.data = req_data.rx_byte;
         end
         OP_READ: begin
            if (byte_access) begin
               unique case (req_data.reg_offset)
                  OFF_DATA:       cmd.kind = CMD_POP;
                  OFF_STATUS:     cmd.kind = CMD_RD_STATUS;
                  OFF_CONTROL:    cmd.kind = CMD_RD_CTRL;
                  OFF_IRQ_STATUS: cmd.kind = CMD_RD_IRQ;
                  default:        cmd.kind = CMD_NOP;
               endcase
            end
         end
         OP_WRITE: begin
            if (byte_access) begin
               unique case (req_data.reg_offset)
                  OFF_DATA:    cmd.kind = (req_data.write_data == CHAR_LF) ? CMD_TX_NL : CMD_TX;
                  OFF_CONTROL: cmd.kind = CMD_WR_CTRL;
                  default:     cmd.kind = CMD_NOP;
               endcase
            end
         end
         default: cmd.kind = CMD_NOP;
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/cuart_cmd_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Console UART command queue
// Short FIFO of decoded commands that decouples the request side from the
// execution side, so a stall on either side holds up the other only once the queue is full or empty.
// ---------------------------------------------------------------------------
module cuart_cmd_queue
   import cuart_pkg::*;
(
   input  var logic    clock,
   input  var logic    reset,
   input  var logic    push,
   input  var cmd_type push_cmd,
   output var logic    full,
   input  var logic    pop,
   output var logic    head_valid,
   output var cmd_type head_cmd
);

   localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type         entry_ff [QUEUE_DEPTH];
   logic [QA_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QA_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = (count_ff == QC_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ===== sv/cuart_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Console UART execution side
// Owns the receive FIFO and the interrupt enable, issues one result
// per cycle while the output register is free and holds each result in
// that register. A newline write yields CR then LF as two results.
// ---------------------------------------------------------------------------
module cuart_back
   import cuart_pkg::*;
(
   input  var logic    clock,
   input  var logic    reset,
   input  var logic    cmd_valid,
   input  var cmd_type cmd,
   output var logic    cmd_pop,
   output var logic    rsp_valid,
   input  var logic    rsp_stall,
   output var rsp_type rsp_data
);

   logic [7:0]          store_ff [FIFO_DEPTH];
   logic [RX_AW-1:0]    head_ff, head_in;
   logic [RX_AW-1:0]    tail_ff, tail_in;
   logic [RX_CNT_W-1:0] count_ff, count_in;
   logic                irq_en_ff, irq_en_in;
   logic                nl_phase_ff, nl_phase_in;
   logic                out_valid_ff;
   rsp_type             out_data_ff;
   rsp_type             result;
   logic                out_free, issue, push_en;
   logic                not_empty;
   logic [RX_CNT_W-1:0] free_cnt;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign issue     = cmd_valid && out_free;
   assign cmd_pop   = issue && ((cmd.kind != CMD_TX_NL) || nl_phase_ff);
   assign not_empty = (count_ff != '0);
   assign push_en   = issue && (cmd.kind == CMD_PUSH) && (count_ff != RX_CNT_W'(FIFO_DEPTH));

   // Execute the head command and form its result from the updated state
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      irq_en_in   = irq_en_ff;
      nl_phase_in = nl_phase_ff;
      result      = '0;
      result.last = 1'b1;
      if (issue) begin
         case (cmd.kind)
            CMD_PUSH: begin
               if (push_en) begin
                  tail_in  = (tail_ff == RX_AW'(FIFO_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_POP: begin
               if (not_empty) begin
                  result.read_data = store_ff[head_ff];
                  head_in  = (head_ff == RX_AW'(FIFO_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            CMD_RD_STATUS: result.read_data = {6'd0, 1'b1, not_empty};
            CMD_RD_CTRL:   result.read_data = {7'd0, irq_en_ff};
            CMD_RD_IRQ:    result.read_data = {7'd0, irq_en_ff && not_empty};
            CMD_WR_CTRL:   irq_en_in = cmd.data[0];
            CMD_TX: begin
               result.tx_valid = 1'b1;
               result.tx_char  = cmd.data;
            end
            CMD_TX_NL: begin
               result.tx_valid = 1'b1;
               result.tx_char  = nl_phase_ff ? CHAR_LF : CHAR_CR;
               result.last     = nl_phase_ff;
               nl_phase_in     = !nl_phase_ff;
            end
            default: ;
         endcase
      end
      free_cnt         = RX_CNT_W'(FIFO_DEPTH) - count_in;
      result.irq_level = irq_en_in && (count_in != '0);
      result.rx_free   = RX_FREE_W'(free_cnt);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         irq_en_ff    <= 1'b0;
         nl_phase_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         irq_en_ff   <= irq_en_in;
         nl_phase_ff <= nl_phase_in;
         if (out_free) begin
            out_valid_ff <= issue;
         end
      end
   end

   // Result register and FIFO storage
   always_ff @(posedge clock) begin
      if (issue) begin
         out_data_ff <= result;
      end
      if (push_en) begin
         store_ff[tail_ff] <= cmd.data;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// Console UART with receive FIFO: self-checking testbench
// Drives host bytes, bus reads and bus writes through the request channel in
// random bursts and checks every response against an in-bench copy of the
// console state, with a stalling receiver and two long hold-offs that back
// the block up.
// ---------------------------------------------------------------------------
module tb_top
   import cuart_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Op value with no function, register bits and run sizing
   localparam logic [1:0] OP_UNUSED       = 2'd3;
   localparam logic [7:0] STATUS_TX_READY = 8'h02;
   localparam int         RANDOM_ITEMS    = 1250;
   localparam int         CYCLE_LIMIT     = 200000;
   localparam int         HOLD_CYCLES     = 250;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   console_uart_with_rx_fifo u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Stimulus and expected responses
   req_type req_todo_q[$];
   rsp_type due_rsp_q[$];
   int      n_total    = 0;
   int      n_accepted = 0;
   int      mismatches = 0;
   int      cycle_count = 0;

   // Shadow of the console state
   logic [7:0] rx_copy [FIFO_DEPTH];
   int         rd_ptr  = 0;
   int         wr_ptr  = 0;
   int         fill    = 0;
   logic       irq_en  = 1'b0;

   // Sender and receiver pacing
   int burst_left  = 0;
   int gap_left    = 0;
   int stall_mode  = 0;
   int mode_left   = 0;
   int hold_left   = 0;
   int rx_cycle    = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // One expected response, irq and free count taken from the state now
   function automatic void queue_rsp(input logic [7:0] rd, input logic txv,
                                     input logic [7:0] txc, input logic lst);
      rsp_type r;
      r.read_data = rd;
      r.tx_valid  = txv;
      r.tx_char   = txc;
      r.irq_level = irq_en && (fill != 0);
      r.rx_free   = RX_FREE_W'(FIFO_DEPTH - fill);
      r.last      = lst;
      due_rsp_q.push_back(r);
   endfunction

   // Apply one accepted transfer to the shadow state, queue its responses
   function automatic void advance_console(input req_type r);
      logic [7:0] rd;
      int         tx_n;
      rd   = '0;
      tx_n = 0;
      case (r.op)
         OP_RX_BYTE: begin
            if (fill < FIFO_DEPTH) begin
               rx_copy[wr_ptr] = r.rx_byte;
               wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
               fill++;
            end
         end
         OP_READ: begin
            if (r.access_bytes == ACCESS_BYTE) begin
               case (r.reg_offset)
                  OFF_DATA: begin
                     if (fill != 0) begin
                        rd = rx_copy[rd_ptr];
                        rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
                        fill--;
                     end
                  end
                  OFF_STATUS:     rd = STATUS_TX_READY | {7'd0, fill != 0};
                  OFF_CONTROL:    rd = {7'd0, irq_en};
                  OFF_IRQ_STATUS: rd = {7'd0, irq_en && (fill != 0)};
                  default: ;
               endcase
            end
         end
         OP_WRITE: begin
            if (r.access_bytes == ACCESS_BYTE) begin
               if (r.reg_offset == OFF_DATA) begin
                  tx_n = (r.write_data == CHAR_LF) ? 2 : 1;
               end else if (r.reg_offset == OFF_CONTROL) begin
                  irq_en = r.write_data[0];
               end
            end
         end
         default: ;
      endcase
      // newline goes out as CR then LF
      if (tx_n == 2) begin
         queue_rsp('0, 1'b1, CHAR_CR, 1'b0);
         queue_rsp('0, 1'b1, CHAR_LF, 1'b1);
      end else if (tx_n == 1) begin
         queue_rsp('0, 1'b1, r.write_data, 1'b1);
      end else begin
         queue_rsp(rd, 1'b0, '0, 1'b1);
      end
   endfunction

   function automatic void add_item(input logic [1:0] op, input logic [3:0] off,
                                    input logic [3:0] sz, input logic [7:0] wd,
                                    input logic [7:0] rb);
      req_type r;
      r.op           = op;
      r.reg_offset   = off;
      r.access_bytes = sz;
      r.write_data   = wd;
      r.rx_byte      = rb;
      req_todo_q.push_back(r);
   endfunction

   // Random transfer; push_pct sets how hard the FIFO is filled
   function automatic req_type random_item(input int push_pct);
      req_type r;
      int      pick;
      r.rx_byte      = 8'($urandom_range(0, 255));
      r.write_data   = ($urandom_range(0, 9) == 0) ? CHAR_LF : 8'($urandom_range(0, 255));
      r.access_bytes = ($urandom_range(0, 4) != 0) ? ACCESS_BYTE
                                                   : 4'($urandom_range(0, 15));
      r.reg_offset   = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, 3))
                                                   : 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < push_pct) begin
         r.op = OP_RX_BYTE;
      end else if (pick >= 98) begin
         r.op = OP_UNUSED;
      end else if (pick < push_pct + (100 - push_pct) * 6 / 10) begin
         r.op = OP_READ;
         // bias reads to the data register so the FIFO drains
         if ($urandom_range(0, 1) == 1) r.reg_offset = OFF_DATA;
      end else begin
         r.op = OP_WRITE;
      end
      return r;
   endfunction

   // Stimulus, reset and end of run
   initial begin
      int made;
      int push_pct;
      int phase_len;

      // directed: every register, odd sizes, newline, unused op, field extremes
      add_item(OP_READ,    OFF_DATA,       ACCESS_BYTE, 8'h00, 8'h00);
      add_item(OP_READ,    OFF_STATUS,     ACCESS_BYTE, 8'h00, 8'h00);
      add_item(OP_READ,    OFF_CONTROL,    ACCESS_BYTE, 8'h00, 8'h00);
      add_item(OP_READ,    OFF_IRQ_STATUS, ACCESS_BYTE, 8'h00, 8'h00);
      add_item(OP_WRITE,   OFF_CONTROL,    ACCESS_BYTE, 8'hFF, 8'h00);
      add_item(OP_READ,    OFF_CONTROL,    ACCESS_BYTE, 8'h00, 8'h00);
      add_item(OP_READ,    OFF_IRQ_STATUS, ACCESS_BYTE, 8'h00, 8'h00);
      add_item(OP_RX_BYTE, 4'hF,           4'hF,        8'hFF, 8'h00);
      add_item(OP_RX_BYTE, OFF_DATA,       4'h0,        8'h00, 8'hFF);
      add_item(OP_READ,    OFF_IRQ_STATUS, ACCESS_BYTE, 8'h00, 8'h00);
      add_item(OP_READ,    OFF_STATUS,     ACCESS_BYTE, 8'h00, 8'h00);
      add_item(OP_READ,    OFF_DATA,       4'd2,        8'h00, 8'h00);
      add_item(OP_READ,    OFF_DATA,       ACCESS_BYTE, 8'h00, 8'h00);
      add_item(OP_READ,    OFF_DATA,       ACCESS_BYTE, 8'h00, 8'h00);
      add_item(OP_READ,    OFF_DATA,       ACCESS_BYTE, 8'h00, 8'h00);
      add_item(OP_WRITE,   OFF_DATA,       ACCESS_BYTE, CHAR_LF, 8'h00);
      add_item(OP_WRITE,   OFF_DATA,       ACCESS_BYTE, 8'hFF, 8'h00);
      add_item(OP_WRITE,   OFF_DATA,       4'd8,        CHAR_LF, 8'h00);
      add_item(OP_WRITE,   OFF_DATA,       4'd0,        8'h55, 8'h00);
      add_item(OP_WRITE,   OFF_STATUS,     ACCESS_BYTE, 8'hAA, 8'h00);
      add_item(OP_WRITE,   OFF_IRQ_STATUS, ACCESS_BYTE, 8'h55, 8'h00);
      add_item(OP_READ,    4'hF,           ACCESS_BYTE, 8'h00, 8'h00);
      add_item(OP_READ,    4'h4,           ACCESS_BYTE, 8'h00, 8'h00);
      add_item(OP_UNUSED,  4'hF,           4'hF,        8'hFF, 8'hFF);
      add_item(OP_WRITE,   OFF_CONTROL,    ACCESS_BYTE, 8'hFE, 8'h00);
      add_item(OP_RX_BYTE, OFF_DATA,       ACCESS_BYTE, 8'h00, 8'h5A);
      add_item(OP_READ,    OFF_DATA,       4'hF,        8'h00, 8'h00);

      // random phases, each picked at random as filling, balanced or draining
      made = 0;
      while (made < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0:       push_pct = 85;
            1:       push_pct = 50;
            default: push_pct = 15;
         endcase
         phase_len = $urandom_range(40, 120);
         repeat (phase_len) req_todo_q.push_back(random_item(push_pct));
         made += phase_len;
      end
      n_total = req_todo_q.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (n_accepted < n_total) @(posedge clock);
      while (due_rsp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      #1;
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Driver: bursts of transfers with random gaps, payload held while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_console(req_data);
            n_accepted++;
         end
         if (req_valid && req_stall) begin
            // stalled: keep valid and payload
         end else if (burst_left > 0 && req_todo_q.size() > 0) begin
            req_data  <= req_todo_q.pop_front();
            req_valid <= 1'b1;
            burst_left--;
         end else begin
            req_valid <= 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 30);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // Receiver stall pattern, with long hold-offs at fixed points of its own count
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle == 600 || rx_cycle == 2500) hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(10, 80);
            end
            mode_left--;
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 99) < 30);
               2:       rsp_stall <= ($urandom_range(0, 99) < 70);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
      end
   endtask

   // Monitor: each response transfer against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_rsp_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response, expected none, got %h", $time, rsp_data);
         end else begin
            want = due_rsp_q.pop_front();
            check_field("read_data", want.read_data, rsp_data.read_data);
            check_field("tx_valid",  {7'd0, want.tx_valid},  {7'd0, rsp_data.tx_valid});
            check_field("tx_char",   want.tx_char,   rsp_data.tx_char);
            check_field("irq_level", {7'd0, want.irq_level}, {7'd0, rsp_data.irq_level});
            check_field("rx_free",   {3'd0, want.rx_free},   {3'd0, rsp_data.rx_free});
            check_field("last",      {7'd0, want.last},      {7'd0, rsp_data.last});
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
